FILE: design/hfbt_pkg.sv
package hfbt_pkg;

  typedef enum logic [2:0] {
    ST_ABSORBED = 3'd0,
    ST_EVICTED  = 3'd1,
    ST_VOTE     = 3'd2,
    ST_HIT      = 3'd3,
    ST_MISS     = 3'd4
  } status_t;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_QUERY  = 1'b1
  } action_t;

  typedef struct packed {
    action_t     action;
    logic [9:0]  bucket_index;
    logic [63:0] key_low;
    logic [39:0] key_high;
    logic [15:0] packet_size;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic [63:0] out_key_low;
    logic [39:0] out_key_high;
    logic [31:0] out_total;
    logic [31:0] out_packets;
    logic        out_was_evicted;
  } result_t;

  typedef struct packed {
    logic [39:0] key_high;
    logic [63:0] key_low;
    logic [31:0] total;
    logic [31:0] count;
    logic        mark;
  } slot_t;

  localparam logic [2:0] SWAP_SHIFT_RESET = 3'd3;

endpackage

FILE: design/hfbt_ram.sv
module hfbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/heavy_flow_bucket_table.sv
// Heavy-flow bucket table. After reset the block sweeps its bucket memory to
// zero, one bucket per cycle, with busy high; the swap_shift register may be
// written meanwhile. Afterwards an item is transferred when start is high and
// busy is low. Each item then goes through these steps in order: reading its
// bucket row from the single-port-per-direction memory, updating it and
// writing it back for an insert, and showing the result with done high. The
// next item may be started in the cycle done is high. The receiver cannot
// stall: every result must be taken in the cycle done is high.
module heavy_flow_bucket_table
  import hfbt_pkg::*;
#(
  parameter int BUCKETS = 1024,
  parameter int SLOTS   = 7
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    cfg_we,
  input  logic [2:0] cfg_data,
  input  logic    start,
  input  item_t   item,
  output logic    busy,
  output logic    done,
  output result_t result
);

  localparam int IW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef struct packed {
    logic [31:0]            vote;
    slot_t [SLOTS-1:0]      slots;
  } row_t;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_READ  = 4'b0100,
    S_EXEC  = 4'b1000
  } state_t;

  state_t      state, state_next;
  logic [IW-1:0] clr_cnt;
  logic [2:0]  swap_shift;
  item_t       cur;
  logic [IW-1:0] idx;
  logic [IW-1:0] idx_in;
  logic [9:0]  red;
  row_t        row_rd, row_wr;
  logic        ram_we;
  logic [IW-1:0] ram_waddr;
  logic [$bits(row_t)-1:0] ram_rdata;
  result_t     res_next;
  logic        wb;

  assign busy = (state != S_IDLE);

  // index reduction modulo BUCKETS
  always_comb begin
    logic [26:0] t;
    red = item.bucket_index;
    for (int k = 9; k >= 0; k--) begin
      t = 27'(BUCKETS) << k;
      if (t <= 27'(red)) begin
        red = red - 10'(t);
      end
    end
    idx_in = IW'(red);
  end

  hfbt_ram #(.WIDTH($bits(row_t)), .DEPTH(BUCKETS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (row_wr),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  assign row_rd = row_t'(ram_rdata);

  always_comb begin
    logic [SLOTS-1:0] eq, fr;
    logic          hit, has_free;
    logic [SW-1:0] msel, fsel, nsel;
    logic [31:0]   minv, guard, thresh;
    slot_t         sl;
    row_wr   = row_rd;
    res_next = '0;
    wb       = 1'b0;
    sl       = '0;
    hit = 1'b0; has_free = 1'b0;
    msel = '0; fsel = '0; nsel = '0;
    minv = row_rd.slots[0].total;
    for (int i = 0; i < SLOTS; i++) begin
      eq[i] = (row_rd.slots[i].key_low == cur.key_low) &&
              (row_rd.slots[i].key_high == cur.key_high);
      fr[i] = (row_rd.slots[i].key_low == '0) && (row_rd.slots[i].key_high == '0);
    end
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (eq[i]) begin hit = 1'b1; msel = SW'(i); end
      if (fr[i]) begin has_free = 1'b1; fsel = SW'(i); end
    end
    for (int i = 1; i < SLOTS; i++) begin
      if (row_rd.slots[i].total < minv) begin
        minv = row_rd.slots[i].total;
        nsel = SW'(i);
      end
    end
    guard  = row_rd.vote + 32'(cur.packet_size);
    thresh = minv << swap_shift;
    if (cur.action == ACT_QUERY) begin
      if (hit) begin
        sl = row_rd.slots[msel];
        res_next = '{ST_HIT, sl.key_low, sl.key_high, sl.total, sl.count, sl.mark};
      end else begin
        res_next.status = ST_MISS;
      end
    end else if (hit) begin
      wb = 1'b1;
      row_wr.slots[msel].total = row_rd.slots[msel].total + 32'(cur.packet_size);
      row_wr.slots[msel].count = row_rd.slots[msel].count + 32'd1;
      res_next.status = ST_ABSORBED;
    end else if (has_free) begin
      wb = 1'b1;
      row_wr.slots[fsel].key_low  = cur.key_low;
      row_wr.slots[fsel].key_high = cur.key_high;
      row_wr.slots[fsel].total    = 32'(cur.packet_size);
      row_wr.slots[fsel].count    = 32'd1;
      res_next.status = ST_ABSORBED;
    end else if (guard > thresh) begin
      wb = 1'b1;
      sl = row_rd.slots[nsel];
      res_next = '{ST_EVICTED, sl.key_low, sl.key_high, sl.total, sl.count, sl.mark};
      row_wr.vote = '0;
      row_wr.slots[nsel] = '{cur.key_high, cur.key_low, 32'(cur.packet_size), 32'd1, 1'b1};
    end else begin
      wb = 1'b1;
      row_wr.vote = guard;
      res_next.status = ST_VOTE;
    end
    if (state == S_CLEAR) begin
      row_wr = '0;
    end
  end

  assign ram_we    = (state == S_CLEAR) || ((state == S_EXEC) && wb);
  assign ram_waddr = (state == S_CLEAR) ? clr_cnt : idx;

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr_cnt == IW'(BUCKETS - 1)) state_next = S_IDLE;
      S_IDLE:  if (start) state_next = S_READ;
      S_READ:  state_next = S_EXEC;
      S_EXEC:  state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_cnt    <= '0;
      swap_shift <= SWAP_SHIFT_RESET;
      done       <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + IW'(1);
      end
      if (cfg_we) begin
        swap_shift <= cfg_data;
      end
      done <= (state == S_EXEC);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      cur <= item;
      idx <= idx_in;
    end
    if (state == S_EXEC) begin
      result <= res_next;
    end
  end

endmodule

FILE: design/hfbt_check.sv
module hfbt_check
  import hfbt_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input logic    done,
  input result_t result
);

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("done while busy");

  a_busy_after: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("not busy after transfer");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##3 done) else $error("result missing");

  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !done ##1 !done) else $error("early result");

  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == ST_ABSORBED || result.status == ST_VOTE ||
              result.status == ST_MISS)) |->
    (result.out_key_low == '0 && result.out_key_high == '0 &&
     result.out_total == '0 && result.out_packets == '0 && !result.out_was_evicted))
    else $error("nonzero fields");

endmodule

bind heavy_flow_bucket_table hfbt_check u_check (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .result(result)
);

FILE: sim/testbench.sv
module testbench;
  import hfbt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBUCKETS = 1024;
  localparam int NSLOTS   = 7;
  localparam int CYCLE_LIMIT = 200000;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    cfg_we = 1'b0;
  logic [2:0] cfg_data = '0;
  logic    start = 1'b0;
  item_t   item = '0;
  logic    busy;
  logic    done;
  result_t result;

  heavy_flow_bucket_table #(.BUCKETS(NBUCKETS), .SLOTS(NSLOTS)) u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .start(start), .item(item), .busy(busy), .done(done), .result(result)
  );

  always #6 clk = ~clk;

  // shadow copy of the bucket table
  logic [103:0] tbl_key   [NBUCKETS*NSLOTS];
  logic [31:0]  tbl_total [NBUCKETS*NSLOTS];
  logic [31:0]  tbl_count [NBUCKETS*NSLOTS];
  logic         tbl_mark  [NBUCKETS*NSLOTS];
  logic [31:0]  tbl_vote  [NBUCKETS];
  logic [2:0]   shift_cfg = SWAP_SHIFT_RESET;

  result_t pending_results[$];
  int errors = 0;
  int cycles = 0;

  function automatic result_t predict_flow(item_t it);
    result_t r;
    int base, hit, free_slot, min_slot, c;
    logic [31:0] min_total, new_vote, thresh;
    logic [103:0] k;
    r = '0;
    base = int'(it.bucket_index) * NSLOTS;
    hit = -1; free_slot = -1; min_slot = 0;
    min_total = tbl_total[base];
    k = {it.key_high, it.key_low};
    for (int i = 0; i < NSLOTS; i++) begin
      if (tbl_key[base+i] == k) begin
        hit = i;
        break;
      end
      if (free_slot < 0 && tbl_key[base+i] == '0) free_slot = i;
      if (min_total > tbl_total[base+i]) begin
        min_total = tbl_total[base+i];
        min_slot = i;
      end
    end
    if (it.action == ACT_QUERY) begin
      if (hit >= 0) begin
        c = base + hit;
        r.status = ST_HIT;
        {r.out_key_high, r.out_key_low} = tbl_key[c];
        r.out_total = tbl_total[c];
        r.out_packets = tbl_count[c];
        r.out_was_evicted = tbl_mark[c];
      end else r.status = ST_MISS;
      return r;
    end
    if (hit >= 0) begin
      c = base + hit;
      tbl_total[c] += 32'(it.packet_size);
      tbl_count[c] += 32'd1;
      r.status = ST_ABSORBED;
      return r;
    end
    if (free_slot >= 0) begin
      c = base + free_slot;
      tbl_key[c] = k;
      tbl_total[c] = 32'(it.packet_size);
      tbl_count[c] = 32'd1;
      r.status = ST_ABSORBED;
      return r;
    end
    new_vote = tbl_vote[it.bucket_index] + 32'(it.packet_size);
    thresh = min_total << shift_cfg;
    if (!(new_vote > thresh)) begin
      tbl_vote[it.bucket_index] = new_vote;
      r.status = ST_VOTE;
      return r;
    end
    c = base + min_slot;
    r.status = ST_EVICTED;
    {r.out_key_high, r.out_key_low} = tbl_key[c];
    r.out_total = tbl_total[c];
    r.out_packets = tbl_count[c];
    r.out_was_evicted = tbl_mark[c];
    tbl_vote[it.bucket_index] = '0;
    tbl_key[c] = k;
    tbl_total[c] = 32'(it.packet_size);
    tbl_count[c] = 32'd1;
    tbl_mark[c] = 1'b1;
    return r;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result %p", $time, result);
        errors++;
      end else begin
        result_t want;
        want = pending_results.pop_front();
        if (want !== result) begin
          $display("%0t mismatch: expected %p actual %p", $time, want, result);
          errors++;
        end
      end
    end
  end

  // start stays high after a transfer until the next idle gap or drain
  task automatic send_item(item_t it, bit gaps = 1);
    int gap;
    gap = gaps ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(predict_flow(it));
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_shift(logic [2:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    shift_cfg = v;
  endtask

  function automatic item_t make_item(bit act, logic [9:0] b, logic [103:0] k,
                                      logic [15:0] sz);
    item_t it;
    it.action = act ? ACT_QUERY : ACT_INSERT;
    it.bucket_index = b;
    {it.key_high, it.key_low} = k;
    it.packet_size = sz;
    return it;
  endfunction

  // fill one bucket, absorb, vote up to eviction, query hits and misses
  task automatic test_directed();
    send_item(make_item(1, 10'd0, 104'd5, 16'd0));
    send_item(make_item(0, 10'd0, '0, 16'hFFFF));
    send_item(make_item(1, 10'd0, '0, 16'd0));
    for (int i = 1; i <= NSLOTS; i++)
      send_item(make_item(0, 10'd1023, {40'hFF_FFFF_FFFF, 64'(i)}, 16'(i)), 0);
    send_item(make_item(0, 10'd1023, {40'hFF_FFFF_FFFF, 64'd3}, 16'hFFFF), 0);
    send_item(make_item(0, 10'd1023, {104{1'b1}}, 16'd1), 0);
    send_item(make_item(0, 10'd1023, {104{1'b1}}, 16'd8));
    send_item(make_item(1, 10'd1023, {104{1'b1}}, 16'd0));
    send_item(make_item(1, 10'd1023, {40'hFF_FFFF_FFFF, 64'd3}, 16'd0));
    send_item(make_item(1, 10'd1023, {40'hFF_FFFF_FFFF, 64'd1}, 16'hFFFF));
  endtask

  // random flows from a small key pool over few buckets so buckets fill and evict
  task automatic test_random(int n, int nbuckets);
    logic [103:0] pool[32];
    for (int i = 0; i < 32; i++)
      pool[i] = 104'({$urandom, $urandom, $urandom, $urandom});
    pool[0] = '0;
    for (int i = 0; i < n; i++) begin
      logic [9:0] b;
      logic [103:0] k;
      logic [15:0] sz;
      b = ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, nbuckets-1));
      k = ($urandom_range(0, 7) == 0) ? 104'({$urandom, $urandom, $urandom, $urandom})
                                       : pool[$urandom_range(0, 31)];
      sz = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
      send_item(make_item($urandom_range(0, 4) == 0, b, k, sz), $urandom_range(0, 2) != 0);
    end
  endtask

  initial begin
    for (int i = 0; i < NBUCKETS*NSLOTS; i++) begin
      tbl_key[i] = '0; tbl_total[i] = '0; tbl_count[i] = '0; tbl_mark[i] = 1'b0;
    end
    for (int i = 0; i < NBUCKETS; i++) tbl_vote[i] = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    write_shift(3'd0);
    test_random(250, 3);
    write_shift(3'd7);
    test_random(150, 4);
    write_shift(3'd1);
    test_random(200, 2);
    write_shift(3'd5);
    test_random(150, 6);
    drain();
    if (errors == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end
endmodule
